// ===== rtl/core/command_stream_validator_assert.svh =====
// Assertion helpers for the command stream validator.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef COMMAND_STREAM_VALIDATOR_ASSERT_SVH
`define COMMAND_STREAM_VALIDATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Combinational or implication property, sampled on the rising clock edge.
`define CSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define CSV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define CSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/core/csv_pkg.sv =====
package csv_pkg;

    localparam int HEADER_WORDS = 8;
    localparam int RELOC_WORDS  = 4;

    localparam int WORD_W      = 32;
    localparam int LB_W        = 3;
    localparam int RELOC_CNT_W = 12;
    localparam int BATCH_W     = 20;
    // Largest position that can still be in range: 8 + 4*4095 + 1048575 - 1.
    localparam int POS_W       = 21;
    localparam int REL_END_W   = 15;
    localparam int HDR_IDX_W   = $clog2(HEADER_WORDS);
    localparam int RELOC_IDX_W = $clog2(RELOC_WORDS);

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam int OUT_DATA_W = 64;

    localparam logic [LB_W-1:0] FULL_WORD_BYTES = LB_W'(4);

    localparam logic [WORD_W-1:0]      RST_MAGIC      = 32'd0;
    localparam logic [WORD_W-1:0]      RST_VERSION    = 32'd1;
    localparam logic [WORD_W-1:0]      RST_RENDER_ID  = 32'd0;
    localparam logic [WORD_W-1:0]      RST_COPY_ID    = 32'd1;
    localparam logic [RELOC_CNT_W-1:0] RST_MAX_RELOCS = 12'd64;
    localparam logic [BATCH_W-1:0]     RST_MAX_BATCH  = 20'd16384;
    localparam logic [WORD_W-1:0]      RST_END_WORD   = 32'd83886080;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MAGIC      = 3'd0,
        REG_VERSION    = 3'd1,
        REG_RENDER_ID  = 3'd2,
        REG_COPY_ID    = 3'd3,
        REG_MAX_RELOCS = 3'd4,
        REG_MAX_BATCH  = 3'd5,
        REG_END_WORD   = 3'd6
    } t_reg_idx;

    typedef enum logic [HDR_IDX_W-1:0] {
        HDR_MAGIC   = 3'd0,
        HDR_VERSION = 3'd1,
        HDR_ENGINE  = 3'd2,
        HDR_RELOCS  = 3'd3,
        HDR_BATCH   = 3'd4
    } t_hdr_pos;

    typedef enum logic [RELOC_IDX_W-1:0] {
        RELOC_OFFSET   = 2'd0,
        RELOC_RESERVED = 2'd1
    } t_reloc_pos;

    typedef struct packed {
        logic [WORD_W-1:0]      magic;
        logic [WORD_W-1:0]      version;
        logic [WORD_W-1:0]      render_id;
        logic [WORD_W-1:0]      copy_id;
        logic [RELOC_CNT_W-1:0] max_relocs;
        logic [BATCH_W-1:0]     max_batch;
        logic [WORD_W-1:0]      end_word;
    } t_cfg;

    typedef struct packed {
        logic                   status;
        logic [WORD_W-1:0]      engine_word;
        logic [RELOC_CNT_W-1:0] reloc_count;
        logic [BATCH_W-1:0]     batch_words;
    } t_verdict;

endpackage

// ===== rtl/core/csv_check.sv =====
module csv_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [csv_pkg::WORD_W-1:0] i_word,
    input  logic                       i_last,
    input  logic [csv_pkg::LB_W-1:0]   i_last_bytes,
    input  csv_pkg::t_cfg              i_cfg,
    output csv_pkg::t_verdict          o_verdict
);

    localparam int POS_W = csv_pkg::POS_W;

    logic [POS_W-1:0]                r_pos,      n_pos;
    logic                            r_reject,   n_reject;
    logic [csv_pkg::WORD_W-1:0]      r_engine,   n_engine;
    logic [csv_pkg::RELOC_CNT_W-1:0] r_reloc,    n_reloc;
    logic                            r_reloc_big, n_reloc_big;
    logic [csv_pkg::BATCH_W-1:0]     r_batch,    n_batch;
    logic [csv_pkg::REL_END_W-1:0]   r_rel_end,  n_rel_end;
    logic [POS_W-1:0]                r_last_pos, n_last_pos;

    logic                              in_header;
    logic [csv_pkg::RELOC_IDX_W-1:0]   reloc_k;
    logic                              ok;

    assign in_header = r_pos < POS_W'(csv_pkg::HEADER_WORDS);
    assign reloc_k   = csv_pkg::RELOC_IDX_W'(r_pos - POS_W'(csv_pkg::HEADER_WORDS));

    always_comb begin
        n_reject    = r_reject;
        n_engine    = r_engine;
        n_reloc     = r_reloc;
        n_reloc_big = r_reloc_big;
        n_batch     = r_batch;
        n_rel_end   = r_rel_end;
        n_last_pos  = r_last_pos;

        if (!r_reject) begin
            if (in_header) begin
                unique case (csv_pkg::t_hdr_pos'(r_pos[csv_pkg::HDR_IDX_W-1:0]))
                    csv_pkg::HDR_MAGIC: begin
                        if (i_word != i_cfg.magic) n_reject = 1'b1;
                    end
                    csv_pkg::HDR_VERSION: begin
                        if (i_word != i_cfg.version) n_reject = 1'b1;
                    end
                    csv_pkg::HDR_ENGINE: begin
                        n_engine = i_word;
                        if (i_word != i_cfg.render_id && i_word != i_cfg.copy_id)
                            n_reject = 1'b1;
                    end
                    csv_pkg::HDR_RELOCS: begin
                        n_reloc     = i_word[csv_pkg::RELOC_CNT_W-1:0];
                        n_reloc_big = |i_word[csv_pkg::WORD_W-1:csv_pkg::RELOC_CNT_W];
                        n_rel_end   = csv_pkg::REL_END_W'(csv_pkg::HEADER_WORDS)
                            + csv_pkg::REL_END_W'(csv_pkg::RELOC_WORDS)
                            * csv_pkg::REL_END_W'(i_word[csv_pkg::RELOC_CNT_W-1:0]);
                    end
                    csv_pkg::HDR_BATCH: begin
                        n_batch    = i_word[csv_pkg::BATCH_W-1:0];
                        n_last_pos = POS_W'(r_rel_end)
                            + POS_W'(i_word[csv_pkg::BATCH_W-1:0]) - POS_W'(1);
                        if (r_reloc_big || r_reloc > i_cfg.max_relocs) n_reject = 1'b1;
                        if (i_word == '0
                            || (|i_word[csv_pkg::WORD_W-1:csv_pkg::BATCH_W])
                            || i_word[csv_pkg::BATCH_W-1:0] > i_cfg.max_batch)
                            n_reject = 1'b1;
                    end
                    default: begin
                        // flags and reserved words
                        if (i_word != '0) n_reject = 1'b1;
                    end
                endcase
            end else if (r_pos < POS_W'(r_rel_end)) begin
                if (reloc_k == csv_pkg::RELOC_OFFSET) begin
                    // offset + 1 must stay below the batch length, no wrap
                    if ((|i_word[csv_pkg::WORD_W-1:csv_pkg::BATCH_W])
                        || i_word[csv_pkg::BATCH_W-1:0] >= r_batch - csv_pkg::BATCH_W'(1))
                        n_reject = 1'b1;
                end else if (reloc_k == csv_pkg::RELOC_RESERVED) begin
                    if (i_word != '0) n_reject = 1'b1;
                end
            end else if (r_pos <= r_last_pos) begin
                if (r_pos == r_last_pos && i_word != i_cfg.end_word) n_reject = 1'b1;
            end else begin
                n_reject = 1'b1;
            end
        end

        if (i_last) begin
            n_pos = '0;
        end else if (r_pos != '1) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign ok = !n_reject && !in_header && i_last_bytes == csv_pkg::FULL_WORD_BYTES
        && r_pos == r_last_pos;

    always_comb begin
        o_verdict.status      = !ok;
        o_verdict.engine_word = ok ? r_engine : '0;
        o_verdict.reloc_count = ok ? r_reloc  : '0;
        o_verdict.batch_words = ok ? r_batch  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_reject <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_reject <= i_last ? 1'b0 : n_reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_engine    <= n_engine;
            r_reloc     <= n_reloc;
            r_reloc_big <= n_reloc_big;
            r_batch     <= n_batch;
            r_rel_end   <= n_rel_end;
            r_last_pos  <= n_last_pos;
        end
    end

endmodule

// ===== rtl/core/command_stream_validator.sv =====
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata data_word, tlast last, tuser last_bytes
// m_axis    out  tvalid/tready           tdata engine/reloc/batch, tuser status
// apb       in   psel/penable/pwrite     pwdata register value, prdata readback
//
// One stream word per cycle while no last word waits on a full output register; a
// word is held in the input register, the header and body checks run between it and
// the stream state, and a verdict is registered as its last word leaves the input register.
// Reset (i_rst_n low, synchronous) restores register defaults and clears the
// stream position and reject flag. A stalled output holds only last words
// back; other words keep flowing while a verdict waits.
module command_stream_validator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [csv_pkg::WORD_W-1:0]     s_axis_tdata,   // [31:0] data_word
    input  logic                           s_axis_tlast,   // last
    input  logic [csv_pkg::LB_W-1:0]       s_axis_tuser,   // [2:0] last_bytes

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] engine_word, [43:32] reloc_count, [63:44] batch_words
    output logic [csv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // [0] status

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csv_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [csv_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [csv_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    `include "command_stream_validator_assert.svh"

    csv_pkg::t_cfg     r_cfg;
    csv_pkg::t_verdict verdict;
    csv_pkg::t_reg_idx reg_idx;

    logic                       r_in_valid;
    logic [csv_pkg::WORD_W-1:0] r_in_word;
    logic                       r_in_last;
    logic [csv_pkg::LB_W-1:0]   r_in_lb;
    logic                       advance;

    logic                           r_out_valid;
    logic                           r_out_status;
    logic [csv_pkg::OUT_DATA_W-1:0] r_out_data;

    assign pready  = 1'b1;
    assign reg_idx = csv_pkg::t_reg_idx'(paddr[csv_pkg::CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic      <= csv_pkg::RST_MAGIC;
            r_cfg.version    <= csv_pkg::RST_VERSION;
            r_cfg.render_id  <= csv_pkg::RST_RENDER_ID;
            r_cfg.copy_id    <= csv_pkg::RST_COPY_ID;
            r_cfg.max_relocs <= csv_pkg::RST_MAX_RELOCS;
            r_cfg.max_batch  <= csv_pkg::RST_MAX_BATCH;
            r_cfg.end_word   <= csv_pkg::RST_END_WORD;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                csv_pkg::REG_MAGIC:      r_cfg.magic      <= pwdata;
                csv_pkg::REG_VERSION:    r_cfg.version    <= pwdata;
                csv_pkg::REG_RENDER_ID:  r_cfg.render_id  <= pwdata;
                csv_pkg::REG_COPY_ID:    r_cfg.copy_id    <= pwdata;
                csv_pkg::REG_MAX_RELOCS: r_cfg.max_relocs <= pwdata[csv_pkg::RELOC_CNT_W-1:0];
                csv_pkg::REG_MAX_BATCH:  r_cfg.max_batch  <= pwdata[csv_pkg::BATCH_W-1:0];
                csv_pkg::REG_END_WORD:   r_cfg.end_word   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            csv_pkg::REG_MAGIC:      prdata = r_cfg.magic;
            csv_pkg::REG_VERSION:    prdata = r_cfg.version;
            csv_pkg::REG_RENDER_ID:  prdata = r_cfg.render_id;
            csv_pkg::REG_COPY_ID:    prdata = r_cfg.copy_id;
            csv_pkg::REG_MAX_RELOCS: prdata = csv_pkg::CFG_DATA_W'(r_cfg.max_relocs);
            csv_pkg::REG_MAX_BATCH:  prdata = csv_pkg::CFG_DATA_W'(r_cfg.max_batch);
            csv_pkg::REG_END_WORD:   prdata = r_cfg.end_word;
            default:                 prdata = '0;
        endcase
    end

    // Only a last word needs room in the output register.
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
            r_in_lb   <= s_axis_tuser;
        end
    end

    csv_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_word       (r_in_word),
        .i_last       (r_in_last),
        .i_last_bytes (r_in_lb),
        .i_cfg        (r_cfg),
        .o_verdict    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= verdict.status;
            r_out_data   <= {verdict.batch_words, verdict.reloc_count, verdict.engine_word};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    `CSV_ASSERT(a_reject_zero_payload, i_clk, i_rst_n, r_out_valid && r_out_status |-> r_out_data == '0, "reject verdict carries nonzero payload")
    `CSV_ASSERT(a_accept_in_bounds, i_clk, i_rst_n, r_out_valid && !r_out_status |-> r_out_data[43:32] <= r_cfg.max_relocs && r_out_data[63:44] != '0 && r_out_data[63:44] <= r_cfg.max_batch, "accepted verdict outside configured bounds")
    `CSV_ASSERT_NEXT(a_last_gives_verdict, i_clk, i_rst_n, advance && r_in_last, r_out_valid, "last word did not produce a verdict")
    `CSV_ASSERT_NEXT(a_held_word_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && r_in_last, "stalled stream word lost")

endmodule
